// ===== rtl/assert_macros.svh =====
// assertion helpers included by ssmva_ctrl; empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SSMVA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define SSMVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSMVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSMVA_ASSERT(lbl, expr)
`define SSMVA_ASSERT_IMP(lbl, ante, cons)
`define SSMVA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ssmva_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmva_pkg
// shared widths, opcodes, sequencer states and datapath control bundle
// ----------------------------------------------------------------------------
package ssmva_pkg;

  localparam int IDX_W = 12;
  localparam int VAL_W = 32;
  localparam int ACC_W = 64;
  localparam int LEN_W = 13;

  localparam int DEPTH_DEFAULT = 4096;
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRIP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RD_ACC,
    S_EMIT,
    S_T_RD0,
    S_T_MUL0,
    S_T_WR0,
    S_T_RD1,
    S_T_WR1
  } state_t;

  typedef struct packed {
    logic vec_re;
    logic vec_we;
    logic vec_sel_col;
    logic acc_re;
    logic acc_we;
    logic acc_clr;
    logic acc_sel_col;
    logic mul_en;
  } ctl_t;

endpackage

// ===== rtl/symmetric_sparse_matvec_accumulate.sv =====
// ----------------------------------------------------------------------------
// symmetric_sparse_matvec_accumulate
// symmetric coo sparse matrix times vector with saturating q32.32 accumulators
// ----------------------------------------------------------------------------
// results: a read request passes S_RD_ACC and S_EMIT before its result shows,
//   a range error only S_EMIT; load, triplet and opcode three give no result
// sequencing: one request at a time, the next taken only back in S_IDLE;
//   triplets do two serial read-modify-writes on the single-port result memory
// reset: clears the sequencer and output valid, length returns to 4096;
//   vector and result memories are not cleared and need no clearing pass
module symmetric_sparse_matvec_accumulate #(
  parameter int VECTOR_DEPTH = ssmva_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [1:0]                   opcode,
  input  logic        [ssmva_pkg::IDX_W-1:0]  row_index,
  input  logic        [ssmva_pkg::IDX_W-1:0]  col_index,
  input  logic signed [ssmva_pkg::VAL_W-1:0]  value,
  // length register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [ssmva_pkg::LEN_W-1:0]  cfg_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ssmva_pkg::IDX_W-1:0]  result_index,
  output logic signed [ssmva_pkg::ACC_W-1:0]  result_value,
  output logic                                status
);
  import ssmva_pkg::*;

  ctl_t                    ctl;
  logic        [IDX_W-1:0] row_q, col_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] vec_data;
  logic signed [ACC_W-1:0] acc_data;

  // sequencer: takes one request at a time, checks range against
  // min(length, depth), steps the memories and owns the result register
  // so a finished result can wait while the next request is taken
  ssmva_ctrl #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .row_index    (row_index),
    .col_index    (col_index),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_index (result_index),
    .result_value (result_value),
    .status       (status),
    .ctl          (ctl),
    .row_q        (row_q),
    .col_q        (col_q),
    .val_q        (val_q),
    .acc_data     (acc_data)
  );

  // vector elements, read once for the row and once for the column
  ssmva_vec_store #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_vec (
    .clk     (clk),
    .ctl     (ctl),
    .row     (row_q),
    .col     (col_q),
    .wr_data (val_q),
    .rd_data (vec_data)
  );

  // result accumulators: column update first, then row update, so the
  // diagonal is added twice with the second read seeing the first write
  ssmva_acc_unit #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_acc (
    .clk      (clk),
    .ctl      (ctl),
    .row      (row_q),
    .col      (col_q),
    .coef     (val_q),
    .vec_data (vec_data),
    .rd_data  (acc_data)
  );

endmodule

// ===== rtl/ssmva_vec_store.sv =====
// ----------------------------------------------------------------------------
// ssmva_vec_store
// vector element memory, one port, registered read data
// ----------------------------------------------------------------------------
module ssmva_vec_store #(
  parameter int VECTOR_DEPTH = ssmva_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  ssmva_pkg::ctl_t                     ctl,
  input  logic        [ssmva_pkg::IDX_W-1:0]  row,
  input  logic        [ssmva_pkg::IDX_W-1:0]  col,
  input  logic signed [ssmva_pkg::VAL_W-1:0]  wr_data,
  output logic signed [ssmva_pkg::VAL_W-1:0]  rd_data
);
  import ssmva_pkg::*;

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic signed [VAL_W-1:0] mem [VECTOR_DEPTH];
  logic        [AW-1:0]    addr;

  // indices reaching here are already range checked
  assign addr = ctl.vec_sel_col ? AW'(col) : AW'(row);

  always_ff @(posedge clk) begin
    if (ctl.vec_we) begin
      mem[addr] <= wr_data;
    end
    if (ctl.vec_re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== rtl/ssmva_acc_unit.sv =====
// ----------------------------------------------------------------------------
// ssmva_acc_unit
// accumulator memory with product register and saturating add
// ----------------------------------------------------------------------------
module ssmva_acc_unit #(
  parameter int VECTOR_DEPTH = ssmva_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  ssmva_pkg::ctl_t                     ctl,
  input  logic        [ssmva_pkg::IDX_W-1:0]  row,
  input  logic        [ssmva_pkg::IDX_W-1:0]  col,
  input  logic signed [ssmva_pkg::VAL_W-1:0]  coef,
  input  logic signed [ssmva_pkg::VAL_W-1:0]  vec_data,
  output logic signed [ssmva_pkg::ACC_W-1:0]  rd_data
);
  import ssmva_pkg::*;

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic signed [ACC_W-1:0] mem [VECTOR_DEPTH];
  logic        [AW-1:0]    addr;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;

  assign addr = ctl.acc_sel_col ? AW'(col) : AW'(row);

  // q16.16 times q16.16 is exact q32.32
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= ACC_W'(coef) * ACC_W'(vec_data);
    end
  end

  always_comb begin
    sum_wide = {rd_data[ACC_W-1], rd_data} + {prod[ACC_W-1], prod};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_we) begin
      mem[addr] <= ctl.acc_clr ? '0 : sum_sat;
    end
    if (ctl.acc_re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== rtl/ssmva_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssmva_ctrl
// request sequencer, range check, length register and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssmva_ctrl #(
  parameter int VECTOR_DEPTH = ssmva_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [1:0]                   opcode,
  input  logic        [ssmva_pkg::IDX_W-1:0]  row_index,
  input  logic        [ssmva_pkg::IDX_W-1:0]  col_index,
  input  logic signed [ssmva_pkg::VAL_W-1:0]  value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [ssmva_pkg::LEN_W-1:0]  cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ssmva_pkg::IDX_W-1:0]  result_index,
  output logic signed [ssmva_pkg::ACC_W-1:0]  result_value,
  output logic                                status,
  output ssmva_pkg::ctl_t                     ctl,
  output logic        [ssmva_pkg::IDX_W-1:0]  row_q,
  output logic        [ssmva_pkg::IDX_W-1:0]  col_q,
  output logic signed [ssmva_pkg::VAL_W-1:0]  val_q,
  input  logic signed [ssmva_pkg::ACC_W-1:0]  acc_data
);
  import ssmva_pkg::*;

  state_t             state, state_next;
  logic [1:0]         op_q;
  logic               err_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LEN_W-1:0]   vector_length;
  logic               in_fire, cfg_fire;
  logic               row_ok, col_ok, err;
  logic               out_free, emit_load;

  assign in_fire  = in_valid && !in_stall;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_free = !out_valid || !out_stall;

  assign row_ok = ({1'b0, row_index} < vector_length) && (32'(row_index) < 32'(VECTOR_DEPTH));
  assign col_ok = ({1'b0, col_index} < vector_length) && (32'(col_index) < 32'(VECTOR_DEPTH));
  assign err    = (opcode == OP_LOAD || opcode == OP_TRIP || opcode == OP_READ) &&
                  (!row_ok || (opcode == OP_TRIP && !col_ok));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vector_length <= LEN_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        vector_length <= cfg_data;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= opcode;
      row_q <= row_index;
      col_q <= col_index;
      val_q <= value;
      err_q <= err;
      idx_q <= (opcode == OP_TRIP && row_ok) ? col_index : row_index;
    end
    if (emit_load) begin
      result_index <= idx_q;
      result_value <= err_q ? '0 : acc_data;
      status       <= err_q ? ST_RANGE : ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (err) begin
            state_next = S_EMIT;
          end else begin
            case (opcode)
              OP_LOAD: state_next = S_LOAD;
              OP_TRIP: state_next = S_T_RD0;
              OP_READ: state_next = S_RD_ACC;
              default: state_next = S_IDLE;
            endcase
          end
        end
      end
      S_LOAD:   state_next = S_IDLE;
      S_RD_ACC: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_T_RD0:  state_next = S_T_MUL0;
      S_T_MUL0: state_next = S_T_WR0;
      S_T_WR0:  state_next = S_T_RD1;
      S_T_RD1:  state_next = S_T_WR1;
      S_T_WR1:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    emit_load = 1'b0;
    cfg_ready = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_LOAD: begin
        ctl.vec_we  = 1'b1;
        ctl.acc_we  = 1'b1;
        ctl.acc_clr = 1'b1;
      end
      S_RD_ACC: begin
        ctl.acc_re = 1'b1;
      end
      S_EMIT: begin
        emit_load = out_free;
      end
      S_T_RD0: begin
        // v[row] and acc[col]
        ctl.vec_re      = 1'b1;
        ctl.acc_re      = 1'b1;
        ctl.acc_sel_col = 1'b1;
      end
      S_T_MUL0: begin
        ctl.mul_en      = 1'b1;
        ctl.vec_re      = 1'b1;
        ctl.vec_sel_col = 1'b1;
      end
      S_T_WR0: begin
        // write acc[col], multiply by v[col] into the freed product register
        ctl.acc_we      = 1'b1;
        ctl.acc_sel_col = 1'b1;
        ctl.mul_en      = 1'b1;
      end
      S_T_RD1: begin
        // read acc[row] after the col write so a diagonal sees it
        ctl.acc_re = 1'b1;
      end
      S_T_WR1: begin
        ctl.acc_we = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  `SSMVA_ASSERT(a_acc_port_single, !(ctl.acc_we && ctl.acc_re))
  `SSMVA_ASSERT_IMP(a_sum_after_read, ctl.acc_we && !ctl.acc_clr,
                    $past(ctl.acc_re) || $past(ctl.acc_re, 2))
  `SSMVA_ASSERT_IMP(a_vec_write_load, ctl.vec_we, op_q == OP_LOAD && !err_q)
  `SSMVA_ASSERT_NEXT(a_emit_shows, state == S_EMIT && out_free, out_valid)

endmodule
